// ===== rtl/dsd_pkg.sv =====
`timescale 1ns / 1ps
package dsd_pkg;
    localparam int LOGIT_W   = 8;
    localparam int EXP_W     = 16;
    localparam int SUM_W     = 18;
    localparam int WSUM_W    = 19;
    localparam int NUM_W     = 27;
    localparam int QUOT_W    = 10;
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = 8;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    // one job handed from the front to the back: a decode or a table write
    typedef struct packed {
        logic              load;
        logic [TBL_AW-1:0] idx0;
        logic [TBL_AW-1:0] idx1;
        logic [TBL_AW-1:0] idx2;
        logic [TBL_AW-1:0] idx3;
        logic              last;
        logic [TBL_AW-1:0] waddr;
        logic [EXP_W-1:0]  wdata;
    } job_t;
endpackage

// ===== rtl/dfl_softmax4_distance_decode.sv =====
`timescale 1ns / 1ps
// Four-bin DFL softmax-expectation decode of one box side.
// Path of an accepted decode transfer to its result: queue pop with table read, sums,
// 10-stage restoring divider, output register.
// Throughput: one item per cycle unless the output stalls; loads write the table, no result.
// Reset: rst_n async active low clears pipe valids and queue; table is undefined until written.
module dfl_softmax4_distance_decode
#(
    parameter int QUEUE_DEPTH = dsd_pkg::FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: logit_zero[7:0], logit_one[15:8], logit_two[23:16], logit_three[31:24],
    //        table_index[39:32], table_value[55:40]
    input  logic [55:0] s_axis_tdata,
    // tuser: mode
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: distance_q8[9:0], zeros above
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import dsd_pkg::*;

    logic    fq_valid, fq_ready, qb_valid, qb_ready;
    job_t    fq_job, qb_job;

    // front: find the peak and form table indexes; loads follow decodes in order
    dsd_front u_front
    (
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .mode(s_axis_tuser),
        .logit_zero(s_axis_tdata[7:0]), .logit_one(s_axis_tdata[15:8]),
        .logit_two(s_axis_tdata[23:16]), .logit_three(s_axis_tdata[31:24]),
        .table_index(s_axis_tdata[39:32]), .table_value(s_axis_tdata[55:40]),
        .frame_end(s_axis_tlast),
        .q_ready(fq_ready), .q_valid(fq_valid), .q_job(fq_job)
    );

    // short queue decouples the front from pipeline stalls
    dsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
    );

    // back: table write or lookup, sums, divide, output register
    dsd_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );
endmodule

// ===== rtl/dsd_front.sv =====
`timescale 1ns / 1ps
module dsd_front
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [7:0]            logit_zero,
    input  logic [7:0]            logit_one,
    input  logic [7:0]            logit_two,
    input  logic [7:0]            logit_three,
    input  logic [7:0]            table_index,
    input  logic [15:0]           table_value,
    input  logic                  frame_end,
    input  logic                  q_ready,
    output logic                  q_valid,
    output dsd_pkg::job_t         q_job
);
    import dsd_pkg::*;

    logic signed [LOGIT_W-1:0] m01, m23, peak;

    always_comb
    begin
        m01  = ($signed(logit_one) > $signed(logit_zero)) ? logit_one : logit_zero;
        m23  = ($signed(logit_three) > $signed(logit_two)) ? logit_three : logit_two;
        peak = (m23 > m01) ? m23 : m01;
    end

    // loads travel the queue too, so they stay in order with decodes
    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    always_comb
    begin
        q_job.load  = (mode == MODE_LOAD);
        q_job.idx0  = logit_zero  - peak;
        q_job.idx1  = logit_one   - peak;
        q_job.idx2  = logit_two   - peak;
        q_job.idx3  = logit_three - peak;
        q_job.last  = frame_end;
        q_job.waddr = table_index;
        q_job.wdata = table_value;
    end
endmodule

// ===== rtl/dsd_queue.sv =====
`timescale 1ns / 1ps
module dsd_queue
#(
    parameter int DEPTH = dsd_pkg::FIFO_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  dsd_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output dsd_pkg::job_t rd_data
);
    import dsd_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t           mem [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           wr_fire, rd_fire;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_fire)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_fire)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
        end
    end
endmodule

// ===== rtl/dsd_back.sv =====
`timescale 1ns / 1ps
module dsd_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  dsd_pkg::job_t    job,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_data,
    output logic             out_last
);
    import dsd_pkg::*;
    localparam int DIV_STAGES = QUOT_W;

    // four read ports: one table copy per bin, all written together
    logic [EXP_W-1:0] tbl0 [TBL_DEPTH];
    logic [EXP_W-1:0] tbl1 [TBL_DEPTH];
    logic [EXP_W-1:0] tbl2 [TBL_DEPTH];
    logic [EXP_W-1:0] tbl3 [TBL_DEPTH];

    logic             adv;
    logic             s1_v_reg, s2_v_reg;
    logic             s1_l_reg, s2_l_reg;
    logic [EXP_W-1:0] e0_reg, e1_reg, e2_reg, e3_reg;
    logic [NUM_W-1:0] num_reg;
    logic [SUM_W-1:0] den_reg;

    logic              dv_reg   [DIV_STAGES];
    logic              dl_reg   [DIV_STAGES];
    logic [NUM_W:0]    rem_reg  [DIV_STAGES];
    logic [SUM_W-1:0]  dd_reg   [DIV_STAGES];
    logic [QUOT_W-1:0] q_reg    [DIV_STAGES];
    logic              dv_src   [DIV_STAGES];
    logic              dl_src   [DIV_STAGES];
    logic [NUM_W:0]    rem_src  [DIV_STAGES];
    logic [SUM_W-1:0]  dd_src   [DIV_STAGES];
    logic [QUOT_W-1:0] q_src    [DIV_STAGES];
    logic [NUM_W:0]    trial    [DIV_STAGES];
    logic              fits     [DIV_STAGES];
    logic [NUM_W:0]    rem_next [DIV_STAGES];
    logic [QUOT_W-1:0] q_next   [DIV_STAGES];

    logic [15:0]      od_reg;
    logic             ov_reg, ol_reg;

    // whole pipe stalls when the output holds and is not taken
    assign adv       = !ov_reg || out_ready;
    assign job_ready = adv;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = ol_reg;

    always_ff @(posedge clk)
    begin
        if (adv && job_valid && job.load)
        begin
            tbl0[job.waddr] <= job.wdata;
            tbl1[job.waddr] <= job.wdata;
            tbl2[job.waddr] <= job.wdata;
            tbl3[job.waddr] <= job.wdata;
        end
        if (adv)
        begin
            e0_reg <= tbl0[job.idx0];
            e1_reg <= tbl1[job.idx1];
            e2_reg <= tbl2[job.idx2];
            e3_reg <= tbl3[job.idx3];
        end
    end

    logic [SUM_W-1:0]  sum_c;
    logic [WSUM_W-1:0] wsum_c;
    always_comb
    begin
        sum_c  = SUM_W'(e0_reg) + SUM_W'(e1_reg) + SUM_W'(e2_reg) + SUM_W'(e3_reg);
        wsum_c = WSUM_W'(e1_reg) + WSUM_W'({e2_reg, 1'b0}) + WSUM_W'(e3_reg)
               + WSUM_W'({e3_reg, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_l_reg <= job.last;
            num_reg  <= {wsum_c, 8'd0} + NUM_W'(sum_c >> 1);
            den_reg  <= sum_c;
            s2_l_reg <= s1_l_reg;
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    always_comb
    begin
        dv_src[0]  = s2_v_reg;
        dl_src[0]  = s2_l_reg;
        rem_src[0] = {1'b0, num_reg};
        dd_src[0]  = den_reg;
        q_src[0]   = '0;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            dv_src[i]  = dv_reg[i-1];
            dl_src[i]  = dl_reg[i-1];
            rem_src[i] = rem_reg[i-1];
            dd_src[i]  = dd_reg[i-1];
            q_src[i]   = q_reg[i-1];
        end
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            trial[i]    = (NUM_W+1)'(dd_src[i]) << (DIV_STAGES - 1 - i);
            fits[i]     = (dd_src[i] != '0) && (rem_src[i] >= trial[i]);
            rem_next[i] = fits[i] ? rem_src[i] - trial[i] : rem_src[i];
            q_next[i]   = fits[i] ? (q_src[i] | (QUOT_W'(1) << (DIV_STAGES - 1 - i)))
                                  : q_src[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dl_reg[i]  <= dl_src[i];
                dd_reg[i]  <= dd_src[i];
                rem_reg[i] <= rem_next[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                dv_reg[i] <= dv_src[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= job_valid && !job.load;
            s2_v_reg <= s1_v_reg;
            ov_reg   <= dv_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            od_reg <= {6'd0, q_reg[DIV_STAGES-1]};
            ol_reg <= dl_reg[DIV_STAGES-1];
        end
    end
endmodule

// ===== rtl/dsd_checker.sv =====
`timescale 1ns / 1ps
module dsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 16'd768)
        else $error("distance out of range");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
        else $error("padding bits set");
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(m_axis_tvalid) && !$isunknown(s_axis_tready))
        else $error("handshake unknown");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output dropped while stalled");
endmodule

bind dfl_softmax4_distance_decode dsd_checker u_chk
(
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
